// ===== sv/ket_pkg.sv =====
package ket_pkg;

    localparam int BTN_COUNT = 3;

    typedef enum logic [3:0] {
        OP_KEY_DOWN   = 4'd0,
        OP_KEY_UP     = 4'd1,
        OP_BTN_DOWN   = 4'd2,
        OP_BTN_UP     = 4'd3,
        OP_MOVE       = 4'd4,
        OP_TICK       = 4'd5,
        OP_CLR_KEYS   = 4'd6,
        OP_CLR_BTNS   = 4'd7,
        OP_KILL_KBD   = 4'd8,
        OP_KILL_MOUSE = 4'd9,
        OP_DIS_KEY    = 4'd10,
        OP_QUERY_KEY  = 4'd11,
        OP_QUERY_BTN  = 4'd12
    } t_opcode;

    typedef struct packed {
        logic               key_on;
        logic               key_off;
        logic               key_push;
        logic               key_release;
        logic               key_usable;
        logic               mouse_on;
        logic               mouse_off;
        logic               mouse_push;
        logic               mouse_release;
        logic signed [15:0] pointer_x;
        logic signed [15:0] pointer_y;
    } t_result;

endpackage

// ===== sv/ket_out_buf.sv =====
module ket_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  ket_pkg::t_result i_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output ket_pkg::t_result o_data
);
    import ket_pkg::*;

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    n_main_valid;
    logic    n_skid_valid;
    t_result n_main;
    t_result n_skid;
    logic    in_acc;
    logic    main_free;

    assign o_in_ready  = !r_skid_valid;
    assign o_out_valid = r_main_valid;
    assign o_data      = r_main;
    assign in_acc      = i_in_valid && !r_skid_valid;
    assign main_free   = !r_main_valid || i_out_ready;

    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (main_free) begin
            if (r_skid_valid) begin
                n_main_valid = 1'b1;
                n_main       = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_main_valid = in_acc;
                n_main       = i_data;
            end
        end else if (in_acc) begin
            n_skid_valid = 1'b1;
            n_skid       = i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_main <= n_main;
        r_skid <= n_skid;
    end

    a_skid_needs_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid item held with empty main stage");

    a_skid_moves_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && i_out_ready |=> r_main_valid && r_main == $past(r_skid))
        else $error("skid item not promoted in order");

    a_skid_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && !i_out_ready |=> r_skid_valid && r_skid == $past(r_skid))
        else $error("skid item lost while stalled");

endmodule

// ===== sv/key_edge_tracker.sv =====
// key and pointer state tracker, one event or query per item
// input channel: i_in_valid / o_in_ready with opcode, key code, button and
//   move coordinates; output channel: o_out_valid / i_out_ready with the
//   query flags and the pointer position published at the last frame tick
// every item gives exactly one result item; flags are zero except for queries
// state changes at the edge the item is accepted; its result is registered
//   in the output stage (main register, or skid register while stalled)
// throughput is one item per cycle while the receiver takes results; all key
//   and button levels sit in flip-flop vectors, so a frame tick or a force
//   release updates every key in that single cycle
// a two-entry output stage holds results while the receiver stalls: one more
//   item is accepted after the output stalls, then o_in_ready drops until
//   the receiver takes a result
// synchronous reset clears every key and button level and disable mark,
//   enables keyboard and mouse, zeroes the pointer and empties the output
// key codes at or above KEY_COUNT are ignored by events and answer zero
module key_edge_tracker #(
    parameter int KEY_COUNT = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [3:0]         i_opcode,
    input  logic [7:0]         i_key_code,
    input  logic [1:0]         i_button,
    input  logic signed [15:0] i_move_x,
    input  logic signed [15:0] i_move_y,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_key_on,
    output logic               o_key_off,
    output logic               o_key_push,
    output logic               o_key_release,
    output logic               o_key_usable,
    output logic               o_mouse_on,
    output logic               o_mouse_off,
    output logic               o_mouse_push,
    output logic               o_mouse_release,
    output logic signed [15:0] o_pointer_x,
    output logic signed [15:0] o_pointer_y
);
    import ket_pkg::*;

    localparam int KW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

    logic [KEY_COUNT-1:0] r_key_now;
    logic [KEY_COUNT-1:0] r_key_before;
    logic [KEY_COUNT-1:0] r_key_dis;
    logic [BTN_COUNT-1:0] r_btn_now;
    logic [BTN_COUNT-1:0] r_btn_before;
    logic                 r_kbd_en;
    logic                 r_mouse_en;
    logic signed [15:0]   r_pend_x;
    logic signed [15:0]   r_pend_y;
    logic signed [15:0]   r_shown_x;
    logic signed [15:0]   r_shown_y;

    logic [KEY_COUNT-1:0] n_key_now;
    logic [KEY_COUNT-1:0] n_key_before;
    logic [KEY_COUNT-1:0] n_key_dis;
    logic [BTN_COUNT-1:0] n_btn_now;
    logic [BTN_COUNT-1:0] n_btn_before;
    logic                 n_kbd_en;
    logic                 n_mouse_en;
    logic signed [15:0]   n_pend_x;
    logic signed [15:0]   n_pend_y;
    logic signed [15:0]   n_shown_x;
    logic signed [15:0]   n_shown_y;

    logic                 in_acc;
    logic                 key_ok;
    logic                 btn_ok;
    logic [KW-1:0]        key_idx;
    logic                 k_now;
    logic                 k_before;
    logic                 k_usable;
    logic                 k_en;
    logic                 b_now;
    logic                 b_before;
    t_result              res;
    t_result              out_data;

    assign in_acc  = i_in_valid && o_in_ready;
    assign key_ok  = (32'(i_key_code) < 32'(KEY_COUNT));
    assign btn_ok  = (i_button < 2'(BTN_COUNT));
    assign key_idx = KW'(i_key_code);

    assign k_now    = key_ok && r_key_now[key_idx];
    assign k_before = key_ok && r_key_before[key_idx];
    assign k_usable = key_ok && !r_key_dis[key_idx];
    assign k_en     = r_kbd_en && k_usable;
    assign b_now    = btn_ok && r_btn_now[i_button];
    assign b_before = btn_ok && r_btn_before[i_button];

    always_comb begin
        n_key_now    = r_key_now;
        n_key_before = r_key_before;
        n_key_dis    = r_key_dis;
        n_btn_now    = r_btn_now;
        n_btn_before = r_btn_before;
        n_kbd_en     = r_kbd_en;
        n_mouse_en   = r_mouse_en;
        n_pend_x     = r_pend_x;
        n_pend_y     = r_pend_y;
        n_shown_x    = r_shown_x;
        n_shown_y    = r_shown_y;
        res          = '0;
        case (t_opcode'(i_opcode))
            OP_KEY_DOWN: begin
                if (key_ok) n_key_now[key_idx] = 1'b1;
            end
            OP_KEY_UP: begin
                if (key_ok) n_key_now[key_idx] = 1'b0;
            end
            OP_BTN_DOWN: begin
                if (btn_ok) n_btn_now[i_button] = 1'b1;
            end
            OP_BTN_UP: begin
                if (btn_ok) n_btn_now[i_button] = 1'b0;
            end
            OP_MOVE: begin
                n_pend_x = i_move_x;
                n_pend_y = i_move_y;
            end
            OP_TICK: begin
                n_key_before = r_key_now;
                n_key_dis    = '0;
                n_btn_before = r_btn_now;
                n_shown_x    = r_pend_x;
                n_shown_y    = r_pend_y;
                n_kbd_en     = 1'b1;
                n_mouse_en   = 1'b1;
            end
            OP_CLR_KEYS: begin
                n_key_now    = '0;
                n_key_before = '0;
                n_key_dis    = '0;
            end
            OP_CLR_BTNS: begin
                n_btn_now = '0;
            end
            OP_KILL_KBD: begin
                n_kbd_en = 1'b0;
            end
            OP_KILL_MOUSE: begin
                n_mouse_en = 1'b0;
            end
            OP_DIS_KEY: begin
                if (key_ok) n_key_dis[key_idx] = 1'b1;
            end
            OP_QUERY_KEY: begin
                res.key_on      = k_en && k_now;
                res.key_off     = k_en && !k_now;
                res.key_push    = k_en && k_now && !k_before;
                res.key_release = k_en && !k_now && k_before;
                res.key_usable  = k_usable;
            end
            OP_QUERY_BTN: begin
                res.mouse_on      = btn_ok && r_mouse_en && b_now;
                res.mouse_off     = btn_ok && r_mouse_en && !b_now;
                res.mouse_push    = btn_ok && r_mouse_en && b_now && !b_before;
                res.mouse_release = btn_ok && r_mouse_en && !b_now && b_before;
            end
            default: begin
            end
        endcase
        res.pointer_x = n_shown_x;
        res.pointer_y = n_shown_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_now    <= '0;
            r_key_before <= '0;
            r_key_dis    <= '0;
            r_btn_now    <= '0;
            r_btn_before <= '0;
            r_kbd_en     <= 1'b1;
            r_mouse_en   <= 1'b1;
            r_pend_x     <= '0;
            r_pend_y     <= '0;
            r_shown_x    <= '0;
            r_shown_y    <= '0;
        end else if (in_acc) begin
            r_key_now    <= n_key_now;
            r_key_before <= n_key_before;
            r_key_dis    <= n_key_dis;
            r_btn_now    <= n_btn_now;
            r_btn_before <= n_btn_before;
            r_kbd_en     <= n_kbd_en;
            r_mouse_en   <= n_mouse_en;
            r_pend_x     <= n_pend_x;
            r_pend_y     <= n_pend_y;
            r_shown_x    <= n_shown_x;
            r_shown_y    <= n_shown_y;
        end
    end

    ket_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_data      (res),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_data      (out_data)
    );

    assign o_key_on        = out_data.key_on;
    assign o_key_off       = out_data.key_off;
    assign o_key_push      = out_data.key_push;
    assign o_key_release   = out_data.key_release;
    assign o_key_usable    = out_data.key_usable;
    assign o_mouse_on      = out_data.mouse_on;
    assign o_mouse_off     = out_data.mouse_off;
    assign o_mouse_push    = out_data.mouse_push;
    assign o_mouse_release = out_data.mouse_release;
    assign o_pointer_x     = out_data.pointer_x;
    assign o_pointer_y     = out_data.pointer_y;

    a_tick_enables: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_opcode == OP_TICK |=> r_kbd_en && r_mouse_en && r_key_dis == '0)
        else $error("frame tick left an input source disabled");

    a_clear_keys: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_opcode == OP_CLR_KEYS |=> r_key_now == '0 && r_key_before == '0)
        else $error("force release left a key level set");

    a_push_one_hot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot0({o_key_on, o_key_off}) && !(o_key_push && !o_key_on)
            && !(o_key_release && !o_key_off))
        else $error("inconsistent key answer");

endmodule
